// ===== rtl/drs_pkg.sv =====
// drs_pkg: shared types, constants and fixed-point helpers for the dielectric scatter unit
// no dependencies; imported by every rtl module of the block
package drs_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int IDX_W       = 19;
   localparam int RND_W       = 16;
   localparam int DIV_W       = 32 + FRAC_BITS;
   localparam int SQ_IN_W     = 31 + FRAC_BITS;
   localparam int SQ_W        = (SQ_IN_W + 1) / 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int RND_LSH     = (FRAC_BITS >= RND_W) ? FRAC_BITS - RND_W : 0;
   localparam int RND_RSH     = (FRAC_BITS >= RND_W) ? 0 : RND_W - FRAC_BITS;

   localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(98304);

   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] wide_type;
   typedef q_type [2:0]        vec_type;

   localparam q_type Q_MAX = 32'sh7fffffff;
   localparam q_type Q_MIN = 32'sh80000000;
   localparam q_type Q_ONE = q_type'(longint'(1) << FRAC_BITS);

   typedef struct packed {
      q_type       dir_x;
      q_type       dir_y;
      q_type       dir_z;
      q_type       normal_x;
      q_type       normal_y;
      q_type       normal_z;
      q_type       hit_x;
      q_type       hit_y;
      q_type       hit_z;
      logic [15:0] random_fraction;
   } req_type;

   typedef struct packed {
      q_type out_dir_x;
      q_type out_dir_y;
      q_type out_dir_z;
      q_type origin_x;
      q_type origin_y;
      q_type origin_z;
      logic  took_refraction;
      logic  total_internal;
   } rsp_type;

   // one classified ray waiting between the front and the back
   typedef struct packed {
      vec_type         d;
      vec_type         on;
      vec_type         refl;
      vec_type         hit;
      q_type           rnd;
      logic [SQ_W-1:0] len;
      q_type           cos_num;
      logic            leaving;
   } entry_type;

   function automatic q_type sat32(wide_type v);
      if (v > wide_type'(Q_MAX)) return Q_MAX;
      if (v < wide_type'(Q_MIN)) return Q_MIN;
      return q_type'(v[31:0]);
   endfunction

   function automatic q_type mulq(q_type a, q_type b);
      wide_type p;
      p = a * b;
      return sat32(p >>> FRAC_BITS);
   endfunction

   function automatic q_type add_sat(q_type a, q_type b);
      return sat32(wide_type'(a) + wide_type'(b));
   endfunction

   function automatic q_type sub_sat(q_type a, q_type b);
      return sat32(wide_type'(a) - wide_type'(b));
   endfunction

   function automatic q_type scale_rnd(logic [RND_W-1:0] r);
      wide_type w;
      w = wide_type'({1'b0, r});
      w = (w <<< RND_LSH) >>> RND_RSH;
      return q_type'(w[31:0]);
   endfunction

endpackage

// ===== rtl/drs_sqrt.sv =====
// drs_sqrt: pipelined integer square root, one result bit per stage
// depends on drs_pkg
module drs_sqrt import drs_pkg::*; (
   input  logic            clock,
   input  logic            en,
   input  q_type           x,
   output logic [SQ_W-1:0] root
);

   localparam int REM_W = SQ_IN_W + 1;
   typedef logic [REM_W-1:0] rem_type;

   typedef struct packed {
      rem_type         rem;
      logic [SQ_W-1:0] root;
   } sq_stage_type;

   sq_stage_type st_ff [SQ_W];
   sq_stage_type first;

   // remainder keeps v - root^2; test adds 2^(b+1)*root + 2^(2b)
   function automatic sq_stage_type sq_step(sq_stage_type s, int b);
      sq_stage_type o;
      rem_type      trial;
      o = s;
      trial = (rem_type'(s.root) << (b + 1)) | (rem_type'(1) << (2 * b));
      if (s.rem >= trial) begin
         o.rem     = s.rem - trial;
         o.root[b] = 1'b1;
      end
      return o;
   endfunction

   always_comb begin
      first.root = '0;
      if (x > 0) begin
         first.rem = rem_type'({x[30:0], {FRAC_BITS{1'b0}}});
      end else begin
         first.rem = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= sq_step(first, SQ_W - 1);
         for (int k = 1; k < SQ_W; k++) begin
            st_ff[k] <= sq_step(st_ff[k-1], SQ_W - 1 - k);
         end
      end
   end

   assign root = st_ff[SQ_W-1].root;

endmodule

// ===== rtl/drs_div.sv =====
// drs_div: pipelined restoring divider for signed fixed-point quotients, saturated
// depends on drs_pkg
module drs_div import drs_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  q_type       num,
   input  logic [31:0] den,
   output q_type       quot
);

   typedef struct packed {
      logic [31:0]      rem;
      logic [DIV_W-1:0] nq;
      logic [31:0]      den;
      logic             neg;
   } dv_stage_type;

   dv_stage_type st_ff [DIV_W];
   dv_stage_type first;
   logic [DIV_W-1:0] q;
   q_type            q_low;

   // dividend bits leave at the top while quotient bits enter at the bottom
   function automatic dv_stage_type dv_step(dv_stage_type s);
      dv_stage_type o;
      logic [32:0]  trial;
      o = s;
      trial = {s.rem, s.nq[DIV_W-1]};
      if (trial >= {1'b0, s.den}) begin
         o.rem = 32'(trial - {1'b0, s.den});
         o.nq  = {s.nq[DIV_W-2:0], 1'b1};
      end else begin
         o.rem = trial[31:0];
         o.nq  = {s.nq[DIV_W-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      first.rem = '0;
      first.den = den;
      first.neg = num < 0;
      if (num < 0) begin
         first.nq = {32'(~num) + 32'd1, {FRAC_BITS{1'b0}}};
      end else begin
         first.nq = {32'(num), {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= dv_step(first);
         for (int k = 1; k < DIV_W; k++) begin
            st_ff[k] <= dv_step(st_ff[k-1]);
         end
      end
   end

   assign q     = st_ff[DIV_W-1].nq;
   assign q_low = q_type'({1'b0, q[30:0]});

   always_comb begin
      if (st_ff[DIV_W-1].neg) begin
         quot = (|q[DIV_W-1:31]) ? Q_MIN : -q_low;
      end else begin
         quot = (|q[DIV_W-1:31]) ? Q_MAX : q_low;
      end
   end

endmodule

// ===== rtl/drs_queue.sv =====
// drs_queue: short queue of classified rays between the front and the back
// depends on drs_pkg
module drs_queue import drs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/drs_front.sv =====
// drs_front: accepts rays, forms dot products and length, classifies entering or leaving
// depends on drs_pkg and drs_sqrt
module drs_front import drs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] idx,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             push,
   output entry_type        push_data,
   input  logic             queue_full
);

   typedef struct packed {
      vec_type d;
      vec_type n;
      vec_type hit;
      q_type   rnd;
   } ray_type;

   typedef struct packed {
      ray_type ray;
      vec_type pdn;
      vec_type pdd;
   } f1_type;

   typedef struct packed {
      ray_type ray;
      q_type   dn;
      q_type   dd;
   } f2_type;

   typedef struct packed {
      ray_type         ray;
      q_type           dn;
      logic [SQ_W-1:0] len;
      vec_type         m;
      q_type           mi;
   } f3_type;

   logic            en;
   ray_type         ray_in;
   f1_type          f1_ff, f1_in;
   f2_type          f2_ff, f2_in;
   f3_type          f3_ff, f3_in;
   f2_type          sb_ff [SQ_W];
   logic            f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic [SQ_W-1:0] sb_valid_ff;
   logic [SQ_W-1:0] len;
   q_type           idx_q;

   assign idx_q     = q_type'(idx);
   assign en        = !f3_valid_ff || !queue_full;
   assign req_ready = en;
   assign push      = f3_valid_ff && !queue_full;

   always_comb begin
      ray_in.d[0]   = req_data.dir_x;
      ray_in.d[1]   = req_data.dir_y;
      ray_in.d[2]   = req_data.dir_z;
      ray_in.n[0]   = req_data.normal_x;
      ray_in.n[1]   = req_data.normal_y;
      ray_in.n[2]   = req_data.normal_z;
      ray_in.hit[0] = req_data.hit_x;
      ray_in.hit[1] = req_data.hit_y;
      ray_in.hit[2] = req_data.hit_z;
      ray_in.rnd    = scale_rnd(req_data.random_fraction);
      f1_in.ray     = ray_in;
      for (int i = 0; i < 3; i++) begin
         f1_in.pdn[i] = mulq(ray_in.d[i], ray_in.n[i]);
         f1_in.pdd[i] = mulq(ray_in.d[i], ray_in.d[i]);
      end
   end

   always_comb begin
      f2_in.ray = f1_ff.ray;
      f2_in.dn  = sat32(wide_type'(f1_ff.pdn[0]) + wide_type'(f1_ff.pdn[1])
                        + wide_type'(f1_ff.pdn[2]));
      f2_in.dd  = sat32(wide_type'(f1_ff.pdd[0]) + wide_type'(f1_ff.pdd[1])
                        + wide_type'(f1_ff.pdd[2]));
   end

   drs_sqrt u_len (
      .clock (clock),
      .en    (en),
      .x     (f2_ff.dd),
      .root  (len)
   );

   always_comb begin
      f3_in.ray = sb_ff[SQ_W-1].ray;
      f3_in.dn  = sb_ff[SQ_W-1].dn;
      f3_in.len = len;
      for (int i = 0; i < 3; i++) begin
         f3_in.m[i] = mulq(sb_ff[SQ_W-1].dn, sb_ff[SQ_W-1].ray.n[i]);
      end
      f3_in.mi = mulq(idx_q, sb_ff[SQ_W-1].dn);
   end

   // leaving the surface when the direction and normal agree
   always_comb begin
      push_data.d       = f3_ff.ray.d;
      push_data.hit     = f3_ff.ray.hit;
      push_data.rnd     = f3_ff.ray.rnd;
      push_data.len     = f3_ff.len;
      push_data.leaving = f3_ff.dn > 0;
      for (int i = 0; i < 3; i++) begin
         push_data.refl[i] = sat32(wide_type'(f3_ff.ray.d[i]) - 2 * wide_type'(f3_ff.m[i]));
         push_data.on[i]   = (f3_ff.dn > 0) ? sub_sat('0, f3_ff.ray.n[i]) : f3_ff.ray.n[i];
      end
      push_data.cos_num = (f3_ff.dn > 0) ? f3_ff.mi : sub_sat('0, f3_ff.dn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         sb_valid_ff <= '0;
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         sb_valid_ff <= {sb_valid_ff[SQ_W-2:0], f2_valid_ff};
         f3_valid_ff <= sb_valid_ff[SQ_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         sb_ff[0] <= f2_ff;
         for (int k = 1; k < SQ_W; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
         f3_ff    <= f3_in;
      end
   end

endmodule

// ===== rtl/drs_back.sv =====
// drs_back: divisions, refraction, schlick reflectance and final choice of direction
// depends on drs_pkg, drs_div and drs_sqrt
module drs_back import drs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] idx,
   input  logic             queue_empty,
   output logic             pop,
   input  entry_type        head,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   typedef struct packed {
      vec_type on;
      vec_type refl;
      vec_type hit;
      vec_type u;
      vec_type pu;
      vec_type od;
      vec_type t;
      vec_type et;
      vec_type os;
      q_type   rnd;
      q_type   eta;
      q_type   x;
      q_type   ee;
      q_type   r0sq;
      q_type   dt;
      q_type   x2;
      q_type   r1;
      q_type   dt2;
      q_type   x4;
      q_type   w;
      q_type   x5;
      q_type   ew;
      q_type   schl;
      q_type   disc;
      q_type   pnt;
   } work_type;

   logic             en;
   q_type            idx_q;
   vec_type          dv_u;
   q_type            dv_cos, dv_eta, dv_r0;
   entry_type        dv_sb_ff [DIV_W];
   logic [DIV_W-1:0] dv_valid_ff;
   work_type         b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   work_type         b4_ff, b4_in, b5_ff, b5_in, b6_ff, b6_in, b7_ff, b7_in;
   logic [6:1]       b_valid_ff;
   logic             b7_valid_ff;
   work_type         sq_sb_ff [SQ_W];
   logic [SQ_W-1:0]  sq_valid_ff;
   logic [SQ_W-1:0]  sq_root;
   entry_type        ent;
   q_type            cosv;
   logic             tir, reflect;
   q_type            prob;
   vec_type          refr;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;

   assign idx_q     = q_type'(idx);
   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop       = en && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar i = 0; i < 3; i++) begin : g_udiv
      drs_div u_div (
         .clock (clock),
         .en    (en),
         .num   (head.d[i]),
         .den   (32'(head.len)),
         .quot  (dv_u[i])
      );
   end

   drs_div u_cos_div (
      .clock (clock),
      .en    (en),
      .num   (head.cos_num),
      .den   (32'(head.len)),
      .quot  (dv_cos)
   );

   drs_div u_eta_div (
      .clock (clock),
      .en    (en),
      .num   (Q_ONE),
      .den   (32'(idx)),
      .quot  (dv_eta)
   );

   drs_div u_r0_div (
      .clock (clock),
      .en    (en),
      .num   (sub_sat(Q_ONE, idx_q)),
      .den   (32'(add_sat(Q_ONE, idx_q))),
      .quot  (dv_r0)
   );

   // zero length gives zero unit direction and zero cosine
   always_comb begin
      ent         = dv_sb_ff[DIV_W-1];
      b1_in       = '0;
      b1_in.on    = ent.on;
      b1_in.refl  = ent.refl;
      b1_in.hit   = ent.hit;
      b1_in.rnd   = ent.rnd;
      for (int i = 0; i < 3; i++) begin
         b1_in.u[i] = (ent.len != '0) ? dv_u[i] : '0;
      end
      cosv = (ent.len != '0) ? dv_cos : '0;
      if (ent.leaving) begin
         b1_in.eta = idx_q;
      end else if (idx != '0) begin
         b1_in.eta = dv_eta;
      end else begin
         b1_in.eta = Q_MAX;
      end
      b1_in.x = sub_sat(Q_ONE, cosv);
      for (int i = 0; i < 3; i++) begin
         b1_in.pu[i] = mulq(b1_in.u[i], ent.on[i]);
      end
      b1_in.ee   = mulq(b1_in.eta, b1_in.eta);
      b1_in.r0sq = mulq(dv_r0, dv_r0);
   end

   always_comb begin
      b2_in    = b1_ff;
      b2_in.dt = sat32(wide_type'(b1_ff.pu[0]) + wide_type'(b1_ff.pu[1])
                       + wide_type'(b1_ff.pu[2]));
      b2_in.x2 = mulq(b1_ff.x, b1_ff.x);
      b2_in.r1 = sub_sat(Q_ONE, b1_ff.r0sq);
   end

   always_comb begin
      b3_in     = b2_ff;
      b3_in.dt2 = mulq(b2_ff.dt, b2_ff.dt);
      b3_in.x4  = mulq(b2_ff.x2, b2_ff.x2);
      for (int i = 0; i < 3; i++) begin
         b3_in.od[i] = mulq(b2_ff.on[i], b2_ff.dt);
      end
   end

   always_comb begin
      b4_in    = b3_ff;
      b4_in.w  = sub_sat(Q_ONE, b3_ff.dt2);
      b4_in.x5 = mulq(b3_ff.x4, b3_ff.x);
      for (int i = 0; i < 3; i++) begin
         b4_in.t[i] = sub_sat(b3_ff.u[i], b3_ff.od[i]);
      end
   end

   always_comb begin
      b5_in      = b4_ff;
      b5_in.ew   = mulq(b4_ff.ee, b4_ff.w);
      b5_in.schl = mulq(b4_ff.r1, b4_ff.x5);
      for (int i = 0; i < 3; i++) begin
         b5_in.et[i] = mulq(b4_ff.eta, b4_ff.t[i]);
      end
   end

   always_comb begin
      b6_in      = b5_ff;
      b6_in.disc = sub_sat(Q_ONE, b5_ff.ew);
      b6_in.pnt  = add_sat(b5_ff.r0sq, b5_ff.schl);
   end

   drs_sqrt u_disc_sqrt (
      .clock (clock),
      .en    (en),
      .x     (b6_ff.disc),
      .root  (sq_root)
   );

   always_comb begin
      b7_in = sq_sb_ff[SQ_W-1];
      for (int i = 0; i < 3; i++) begin
         b7_in.os[i] = mulq(sq_sb_ff[SQ_W-1].on[i], q_type'(sq_root));
      end
   end

   // total internal reflection forces the mirror direction
   always_comb begin
      tir     = !(b7_ff.disc > 0);
      prob    = tir ? Q_ONE : b7_ff.pnt;
      reflect = tir || (b7_ff.rnd <= prob);
      for (int i = 0; i < 3; i++) begin
         refr[i] = sub_sat(b7_ff.et[i], b7_ff.os[i]);
      end
      rsp_data_in.out_dir_x       = reflect ? b7_ff.refl[0] : refr[0];
      rsp_data_in.out_dir_y       = reflect ? b7_ff.refl[1] : refr[1];
      rsp_data_in.out_dir_z       = reflect ? b7_ff.refl[2] : refr[2];
      rsp_data_in.origin_x        = b7_ff.hit[0];
      rsp_data_in.origin_y        = b7_ff.hit[1];
      rsp_data_in.origin_z        = b7_ff.hit[2];
      rsp_data_in.took_refraction = !reflect;
      rsp_data_in.total_internal  = tir;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff  <= '0;
         b_valid_ff   <= '0;
         sq_valid_ff  <= '0;
         b7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         dv_valid_ff  <= {dv_valid_ff[DIV_W-2:0], !queue_empty};
         b_valid_ff   <= {b_valid_ff[5:1], dv_valid_ff[DIV_W-1]};
         sq_valid_ff  <= {sq_valid_ff[SQ_W-2:0], b_valid_ff[6]};
         b7_valid_ff  <= sq_valid_ff[SQ_W-1];
         rsp_valid_ff <= b7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_sb_ff[0] <= head;
         for (int k = 1; k < DIV_W; k++) begin
            dv_sb_ff[k] <= dv_sb_ff[k-1];
         end
         b1_ff       <= b1_in;
         b2_ff       <= b2_in;
         b3_ff       <= b3_in;
         b4_ff       <= b4_in;
         b5_ff       <= b5_in;
         b6_ff       <= b6_in;
         sq_sb_ff[0] <= b6_ff;
         for (int k = 1; k < SQ_W; k++) begin
            sq_sb_ff[k] <= sq_sb_ff[k-1];
         end
         b7_ff       <= b7_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/dielectric_ray_scatter_unit.sv =====
// throughput: one ray per cycle while neither side stalls, set by fully pipelined dividers and square root units
// the front (dot products, length root) and back (divisions, schlick, root of the
// discriminant) stall independently, parted by a four-entry queue
// reset: synchronous, active high; clears all valid state and loads the index with 1.5
// the refractive index register is written by csr_wr_en with no wait state
module dielectric_ray_scatter_unit import drs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data
);

   // material index, unsigned with FRAC_BITS fraction bits
   logic [IDX_W-1:0] idx_ff;

   // queue handshake between front and back
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;
   entry_type push_data;
   entry_type head;

   // index register; the user must change it only while no transaction is in flight, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_RESET;
      end else if (csr_wr_en) begin
         idx_ff <= csr_wr_data;
      end
   end

   // front: takes rays, forms d.n, |d| and the reflection, picks the oriented normal
   drs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .idx        (idx_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // short queue so a stalled result does not hold up the front
   drs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // back: unit direction, ratio, refraction, reflectance and the final choice
   drs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .idx         (idx_ff),
      .queue_empty (queue_empty),
      .pop         (pop),
      .head        (head),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/drs_checker.sv =====
// drs_checker: port-level assertions for the dielectric scatter unit, bound to the top level
// depends on drs_pkg and dielectric_ray_scatter_unit
module drs_checker import drs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed or dropped");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready for a transaction after reset");

   a_tir_reflects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_internal |-> !rsp_data.took_refraction)
      else $error("refraction taken under total internal reflection");

endmodule

bind dielectric_ray_scatter_unit drs_checker u_drs_checker (.*);

// ===== tb/tb.sv =====
// tb: self-checking bench for dielectric_ray_scatter_unit; rays go in, scattered rays are checked
// depends on drs_pkg and the rtl of the unit; bit-exact fixed-point predictor kept in this file
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import drs_pkg::*;

   localparam int  SETTLE_CYCLES = 150;     // longer than the full pipeline
   localparam int  CYCLE_LIMIT   = 400000;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [IDX_W-1:0] csr_wr_data;

   rsp_type          expected_scatter[$];
   logic [IDX_W-1:0] cur_index;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               hold_off_left;
   int               fail_count;
   int               ray_count;
   int               tir_count;
   int               refr_count;
   int               cycle_count;

   dielectric_ray_scatter_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // free-running clock with a watchdog on the cycle count
   initial begin
      clock = 1'b0;
      cycle_count = 0;
      forever begin
         #5 clock = ~clock;
         if (clock) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
               $display("dielectric_ray_scatter_unit test failed");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // fixed-point predictor: every intermediate saturated to 32 bits signed
   // ---------------------------------------------------------------------------------------
   function automatic longint clamp_q(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   // exact product, arithmetic shift rounds toward minus infinity
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp_q(p >>> FRAC_BITS);
   endfunction

   // quotient rounded toward zero, magnitude capped before saturation
   function automatic longint qdiv(longint num, longint den);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag << FRAC_BITS) / longint'(den);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return clamp_q((num < 0) ? -longint'(q) : longint'(q));
   endfunction

   // floor of the root of x scaled up by the fraction, bit by bit
   function automatic longint qroot(longint x);
      longint unsigned v, res, bitv;
      if (x <= 0) return 0;
      v = longint'(x) << FRAC_BITS;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return clamp_q(longint'(res));
   endfunction

   function automatic longint qdot(longint a0, longint a1, longint a2,
                                   longint b0, longint b1, longint b2);
      return clamp_q(qmul(a0, b0) + qmul(a1, b1) + qmul(a2, b2));
   endfunction

   function automatic rsp_type scatter_ray(req_type r, logic [IDX_W-1:0] index_q);
      longint  one, idx, dn, len, eta, cosv, dt, disc, prob, rnd, sq, r0, x, x5, t;
      longint  d[3], n[3], on[3], u[3], refl[3], refr[3];
      logic    tir, reflect;
      rsp_type o;
      one = longint'(1) << FRAC_BITS;
      idx = longint'(index_q);
      d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
      n[0] = r.normal_x; n[1] = r.normal_y; n[2] = r.normal_z;
      rnd = longint'(r.random_fraction);
      rnd = (rnd << RND_LSH) >> RND_RSH;

      dn = qdot(d[0], d[1], d[2], n[0], n[1], n[2]);
      for (int i = 0; i < 3; i++) refl[i] = clamp_q(d[i] - 2 * qmul(dn, n[i]));
      len = qroot(qdot(d[0], d[1], d[2], d[0], d[1], d[2]));

      // leaving the surface: flip the normal and use the index itself as the ratio
      if (dn > 0) begin
         for (int i = 0; i < 3; i++) on[i] = clamp_q(-n[i]);
         eta = idx;
         cosv = (len > 0) ? qdiv(qmul(idx, dn), len) : 0;
      end else begin
         for (int i = 0; i < 3; i++) on[i] = n[i];
         eta = (idx > 0) ? clamp_q((longint'(1) << (2 * FRAC_BITS)) / idx) : QMAX;
         cosv = (len > 0) ? qdiv(clamp_q(-dn), len) : 0;
      end

      for (int i = 0; i < 3; i++) u[i] = (len > 0) ? qdiv(d[i], len) : 0;
      dt = qdot(u[0], u[1], u[2], on[0], on[1], on[2]);
      disc = clamp_q(one - qmul(qmul(eta, eta), clamp_q(one - qmul(dt, dt))));
      tir = !(disc > 0);

      if (tir) begin
         for (int i = 0; i < 3; i++) refr[i] = 0;
         prob = one;
      end else begin
         sq = qroot(disc);
         for (int i = 0; i < 3; i++) begin
            t = clamp_q(u[i] - qmul(on[i], dt));
            refr[i] = clamp_q(qmul(eta, t) - qmul(on[i], sq));
         end
         // schlick reflectance from the material index
         r0 = qdiv(clamp_q(one - idx), clamp_q(one + idx));
         r0 = qmul(r0, r0);
         x = clamp_q(one - cosv);
         x5 = qmul(x, x);
         x5 = qmul(x5, x5);
         x5 = qmul(x5, x);
         prob = clamp_q(r0 + qmul(clamp_q(one - r0), x5));
      end

      reflect = tir || (rnd <= prob);
      o.out_dir_x = q_type'(reflect ? refl[0] : refr[0]);
      o.out_dir_y = q_type'(reflect ? refl[1] : refr[1]);
      o.out_dir_z = q_type'(reflect ? refl[2] : refr[2]);
      o.origin_x = r.hit_x;
      o.origin_y = r.hit_y;
      o.origin_z = r.hit_z;
      o.took_refraction = !reflect;
      o.total_internal = tir;
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // result side: random stalls, long hold-off on request, in-order checking
   // ---------------------------------------------------------------------------------------
   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scatter.size() == 0) begin
            $error("unexpected rsp transaction");
            fail_count++;
         end else begin
            e = expected_scatter.pop_front();
            check_field("out_dir_x", e.out_dir_x, rsp_data.out_dir_x);
            check_field("out_dir_y", e.out_dir_y, rsp_data.out_dir_y);
            check_field("out_dir_z", e.out_dir_z, rsp_data.out_dir_z);
            check_field("origin_x", e.origin_x, rsp_data.origin_x);
            check_field("origin_y", e.origin_y, rsp_data.origin_y);
            check_field("origin_z", e.origin_z, rsp_data.origin_z);
            check_field("took_refraction", e.took_refraction, rsp_data.took_refraction);
            check_field("total_internal", e.total_internal, rsp_data.total_internal);
         end
      end
      // hold-off counted here so the sender keeps going and the pipe fills
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------------------
   // offers one ray, returns at the accepting edge with valid still high
   task automatic send_ray(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_scatter.push_back(scatter_ray(r, cur_index));
      ray_count++;
      if (expected_scatter[$].total_internal) tir_count++;
      if (expected_scatter[$].took_refraction) refr_count++;
   endtask

   // sender pauses until every result is back, then lets the pipe settle
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_scatter.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_index(logic [IDX_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_index    = v;
      @(posedge clock);
   endtask

   function automatic q_type rand_q();
      case ($urandom_range(7))
         0:       return q_type'($urandom);
         1:       return ($urandom_range(1)) ? Q_MAX : Q_MIN;
         2:       return q_type'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
         default: return q_type'(int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE);
      endcase
   endfunction

   // mostly plausible rays near unit length, with some full-range noise
   function automatic req_type rand_ray();
      req_type r;
      r.dir_x    = rand_q();
      r.dir_y    = rand_q();
      r.dir_z    = rand_q();
      r.normal_x = rand_q();
      r.normal_y = rand_q();
      r.normal_z = rand_q();
      r.hit_x    = q_type'($urandom);
      r.hit_y    = q_type'($urandom);
      r.hit_z    = q_type'($urandom);
      r.random_fraction = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic req_type make_ray(q_type dx, q_type dy, q_type dz,
                                        q_type nx, q_type ny, q_type nz,
                                        logic [15:0] rf);
      req_type r;
      r = '{dir_x: dx, dir_y: dy, dir_z: dz, normal_x: nx, normal_y: ny, normal_z: nz,
            hit_x: q_type'($urandom), hit_y: q_type'($urandom), hit_z: q_type'($urandom),
            random_fraction: rf};
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------
   // corner rays: zero length, extremes, head-on both ways, grazing exit, rnd bounds
   task automatic test_directed;
      q_type h;
      h = Q_ONE / 2;
      send_ray(make_ray(0, 0, 0, 0, 0, Q_ONE, 16'h0000));
      send_ray(make_ray(0, 0, 0, 0, Q_ONE, 0, 16'hffff));
      send_ray(make_ray(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hffff));
      send_ray(make_ray(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'h0000));
      send_ray(make_ray(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 16'h8000));
      send_ray(make_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, 16'hffff));     // entering head-on
      send_ray(make_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, 16'h0000));
      send_ray(make_ray(0, 0, Q_ONE, 0, 0, Q_ONE, 16'hffff));      // leaving head-on
      send_ray(make_ray(Q_ONE - 200, 0, 300, 0, 0, Q_ONE, 16'hffff)); // grazing exit
      send_ray(make_ray(h, 0, -h, 0, 0, Q_ONE, 16'h1234));
      send_ray(make_ray(h, h, h, 0, Q_ONE, 0, 16'hfffe));
      send_ray(make_ray(-h, 3 * h, -h, 0, -Q_ONE, 0, 16'h0001));
      send_ray(make_ray(0, Q_ONE, 0, Q_MIN, 0, 0, 16'h4000));      // non-unit normal
      send_ray(make_ray(1, -1, 1, 0, 0, Q_ONE, 16'h7fff));
   endtask

   task automatic test_random(int items, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (items) send_ray(rand_ray());
      drain();
   endtask

   // receiver stops for a long stretch while rays keep coming
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = 400;
      repeat (200) send_ray(rand_ray());
      drain();
   endtask

   // index extremes, zero and out of range, each with a burst of rays
   task automatic test_index_sweep;
      logic [IDX_W-1:0] idx_set[7];
      idx_set = '{IDX_W'(65536), IDX_W'(262144), IDX_W'(0), {IDX_W{1'b1}},
                  IDX_W'(32768), IDX_W'(131072), IDX_RESET};
      foreach (idx_set[k]) begin
         write_index(idx_set[k]);
         send_idle_pct = 10;
         recv_idle_pct = 10;
         test_directed();
         repeat (60) send_ray(rand_ray());
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      rsp_ready    <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      cur_index     = IDX_RESET;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = 0;
      fail_count    = 0;
      ray_count     = 0;
      tir_count     = 0;
      refr_count    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();                       // reset index of 1.5
      drain();
      test_random(450, 16, 65);
      write_index(IDX_W'(262144));
      test_random(450, 65, 16);
      write_index(IDX_W'(65536 + 16384));
      test_random(450, 0, 0);
      test_backpressure();
      test_index_sweep();

      $display("covered %0d rays: %0d refracted, %0d total internal reflection",
               ray_count, refr_count, tir_count);
      $display("index settings from zero to all ones, random stalls and a long hold-off");
      if (fail_count == 0) begin
         $display("dielectric_ray_scatter_unit test passed");
      end else begin
         $display("dielectric_ray_scatter_unit test failed");
      end
      $finish;
   end

endmodule
